// ----- design/mbps_pkg.sv -----
package mbps_pkg;

  localparam int unsigned MAX_PATTERN = 256;
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned LEN_BITS    = $clog2(MAX_PATTERN + 1);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_MATCH     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
    logic       care;
    logic       last_byte;
  } mbps_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] match_offset;
  } mbps_out_t;

  // One pattern position as it moves along the row on a load.
  typedef struct packed {
    logic       active;
    logic       care;
    logic [7:0] pat;
  } mbps_slot_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
  } mbps_ctrl_t;

endpackage

// ----- design/mbps_cell.sv -----
module mbps_cell
  import mbps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mbps_ctrl_t ctrl_i,
  input  mbps_slot_t slot_i,
  output mbps_slot_t slot_o,
  input  logic [7:0] byte_i,
  input  logic       flag_i,
  output logic       flag_o,
  output logic       partial_o
);

  logic       active_q;
  logic       care_q;
  logic [7:0] pat_q;
  logic       flag_q;
  logic       hit;

  // Cell k holds the pattern byte that must meet the region byte seen k scans ago.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      flag_q   <= 1'b1;
    end else begin
      if (ctrl_i.clear) begin
        active_q <= 1'b0;
      end else if (ctrl_i.load) begin
        active_q <= slot_i.active;
      end
      if (ctrl_i.scan) begin
        flag_q <= partial_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      care_q <= slot_i.care;
      pat_q  <= slot_i.pat;
    end
  end

  assign hit       = !active_q || !care_q || (pat_q == byte_i);
  assign partial_o = hit && flag_i;
  // An idle cell passes a pass flag so the chain starts at the oldest active cell.
  assign flag_o    = active_q ? flag_q : 1'b1;
  assign slot_o    = '{active: active_q, care: care_q, pat: pat_q};

endmodule

// ----- design/mbps_skid.sv -----
module mbps_skid
  import mbps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mbps_out_t data_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mbps_out_t out_data_o
);

  logic      out_valid_q;
  logic      skid_valid_q;
  mbps_out_t out_q;
  mbps_out_t skid_q;
  logic      out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= push_i;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push_i) begin
          skid_q <= data_i;
        end
      end else if (push_i) begin
        out_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("word pushed while both slots are full");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> out_valid_q)
    else $error("skid word lost when output drained");

endmodule

// ----- design/masked_byte_pattern_search.sv -----
// Channel | Direction | Handshake                     | Word
// in      | input     | in_valid_i / in_ready_o       | in_data_i  (mbps_in_t)
// out     | output    | out_valid_o / out_ready_i     | out_data_o (mbps_out_t)
//
// Every accepted word gives one registered result word. A new word is taken every
// cycle while the skid slot is empty; the compare runs along a row of MAX_PATTERN
// cells, each passing a partial-match flag to its neighbor on every scan.
// An output register plus a skid slot keep in_ready_o high while one result waits.
// rst_ni clears the pattern length, the scan state and both output slots.
module masked_byte_pattern_search
  import mbps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mbps_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mbps_out_t out_data_o
);

  logic [LEN_BITS-1:0]    len_q, len_d;
  logic [OFFSET_BITS-1:0] seen_q, seen_d;
  logic                   found_q, found_d;

  logic                   in_fire;
  logic                   load_go;
  logic                   scan_go;
  logic                   match;
  logic [OFFSET_BITS-1:0] seen_inc;
  logic [OFFSET_BITS-1:0] diff;
  mbps_ctrl_t             ctrl;
  mbps_out_t              res;

  mbps_slot_t             slot_in  [MAX_PATTERN];
  mbps_slot_t             slot_out [MAX_PATTERN];
  logic [MAX_PATTERN:0]   flag;
  logic [MAX_PATTERN-1:0] partial;

  assign in_fire = in_valid_i && in_ready_o;
  assign load_go = in_fire && (in_data_i.command == CMD_LOAD)
                   && (len_q != LEN_BITS'(MAX_PATTERN));
  assign scan_go = in_fire && (in_data_i.command == CMD_SCAN) && !found_q;

  assign ctrl.clear = in_fire && (in_data_i.command == CMD_CLEAR);
  assign ctrl.load  = load_go;
  assign ctrl.scan  = scan_go;

  assign flag[MAX_PATTERN] = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign slot_in[k] = '{active: 1'b1, care: in_data_i.care, pat: in_data_i.byte_value};
    end else begin : g_body
      assign slot_in[k] = slot_out[k-1];
    end
    mbps_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .slot_i    (slot_in[k]),
      .slot_o    (slot_out[k]),
      .byte_i    (in_data_i.byte_value),
      .flag_i    (flag[k+1]),
      .flag_o    (flag[k]),
      .partial_o (partial[k])
    );
  end

  assign seen_inc = (seen_q == '1) ? seen_q : seen_q + 1'b1;
  assign diff     = seen_inc - OFFSET_BITS'(len_q);
  // The window is only complete once as many bytes as the pattern has been scanned.
  assign match    = scan_go && (len_q != '0) && (seen_inc >= OFFSET_BITS'(len_q))
                    && partial[0];

  always_comb begin
    len_d            = len_q;
    seen_d           = seen_q;
    found_d          = found_q;
    res.status       = ST_NONE;
    res.match_offset = '0;
    if (ctrl.clear) begin
      len_d   = '0;
      seen_d  = '0;
      found_d = 1'b0;
    end else if (load_go) begin
      len_d   = len_q + 1'b1;
      seen_d  = '0;
      found_d = 1'b0;
    end else if (scan_go) begin
      seen_d = seen_inc;
      if (match) begin
        found_d          = 1'b1;
        res.status       = ST_MATCH;
        res.match_offset = 32'(diff);
      end else if (in_data_i.last_byte) begin
        res.status = ST_NOT_FOUND;
        seen_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      seen_q  <= '0;
      found_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      seen_q  <= seen_d;
      found_q <= found_d;
    end
  end

  mbps_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .data_i      (res),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_BITS'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  a_frozen_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && found_q && (in_data_i.command == CMD_SCAN)) |=> $stable(seen_q) && found_q)
    else $error("scan state moved after first match");

  a_match_needs_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match |-> (len_q != '0) && !found_q)
    else $error("match reported with empty pattern or after earlier match");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import mbps_pkg::*;

  // The command encoding leaves one code free; the block must ignore it.
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned STALL_LEN    = 60;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  mbps_in_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mbps_out_t out_word;

  masked_byte_pattern_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the search state, advanced once per accepted word.
  logic [7:0]             pat_mem    [MAX_PATTERN];
  logic                   care_mem   [MAX_PATTERN];
  logic [7:0]             window_mem [MAX_PATTERN];
  int unsigned            pat_len = 0;
  logic [OFFSET_BITS-1:0] scanned_cnt = '0;
  bit                     matched = 1'b0;

  mbps_in_t    pending_words[$];
  mbps_out_t   expected_results[$];
  mbps_out_t   head_result;
  int unsigned total_words = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_matches = 0;
  int unsigned n_not_found = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned stalls_done = 0;
  int unsigned stall_at [2];

  function automatic mbps_out_t search_step(mbps_in_t w);
    mbps_out_t r;
    bit        hit;
    r = '0;
    case (w.command)
      CMD_CLEAR: begin
        pat_len     = 0;
        scanned_cnt = '0;
        matched     = 1'b0;
      end
      CMD_LOAD: begin
        if (pat_len < MAX_PATTERN) begin
          pat_mem[pat_len]  = w.byte_value;
          care_mem[pat_len] = w.care;
          pat_len++;
          scanned_cnt = '0;
          matched     = 1'b0;
        end
      end
      CMD_SCAN: begin
        if (!matched) begin
          for (int i = MAX_PATTERN - 1; i > 0; i--) window_mem[i] = window_mem[i-1];
          window_mem[0] = w.byte_value;
          if (scanned_cnt != '1) scanned_cnt++;
          // Only bytes shifted in since the last restart take part in the compare.
          hit = (pat_len != 0) && (scanned_cnt >= pat_len);
          for (int j = 0; j < pat_len && hit; j++) begin
            if (care_mem[j] && window_mem[pat_len-1-j] != pat_mem[j]) hit = 1'b0;
          end
          if (hit) begin
            matched        = 1'b1;
            r.status       = ST_MATCH;
            r.match_offset = 32'(scanned_cnt - pat_len);
          end else if (w.last_byte) begin
            r.status    = ST_NOT_FOUND;
            scanned_cnt = '0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic push_word(logic [1:0] cmd, logic [7:0] val, logic c, logic l);
    mbps_in_t w;
    w.command    = cmd;
    w.byte_value = val;
    w.care       = c;
    w.last_byte  = l;
    pending_words.push_back(w);
  endtask

  // Clear, load a pattern, then scan one or more regions, usually with the
  // pattern planted somewhere inside so that a match completes.
  task automatic queue_search(int unsigned plen, int unsigned n_regions, bit plant);
    logic [7:0]  pat  [MAX_PATTERN];
    logic        pcare[MAX_PATTERN];
    int unsigned eff_len;
    int unsigned region_len;
    int unsigned at;
    logic [7:0]  b;
    eff_len = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
    push_word(CMD_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom);
      if (i < MAX_PATTERN) begin
        pat[i]   = b;
        pcare[i] = ($urandom_range(99) < 70);
      end
      push_word(CMD_LOAD, b, (i < MAX_PATTERN) ? pcare[i] : 1'($urandom), 1'($urandom));
    end
    for (int r = 0; r < n_regions; r++) begin
      // A load between regions restarts the scan, even after a match.
      if (r != 0 && eff_len < MAX_PATTERN && $urandom_range(99) < 30) begin
        pat[eff_len]   = 8'($urandom);
        pcare[eff_len] = 1'($urandom);
        push_word(CMD_LOAD, pat[eff_len], pcare[eff_len], 1'($urandom));
        eff_len++;
      end
      region_len = eff_len + $urandom_range(12) + 1;
      at = (plant && eff_len != 0) ? $urandom_range(region_len - eff_len) : region_len;
      for (int k = 0; k < region_len; k++) begin
        if (k >= at && k < at + eff_len && pcare[k-at]) b = pat[k-at];
        else if (eff_len != 0 && $urandom_range(1)) b = pat[$urandom_range(eff_len - 1)];
        else b = 8'($urandom);
        if ($urandom_range(99) < 2) begin
          push_word(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
        end
        push_word(CMD_SCAN, b, 1'($urandom), k == region_len - 1);
      end
    end
  endtask

  function automatic int unsigned idle_percent(bit rx_side);
    int unsigned third;
    third = total_words / 3;
    if (n_accepted < third) return rx_side ? 55 : 23;
    if (n_accepted < 2 * third) return rx_side ? 23 : 55;
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_word    <= '0;
      n_accepted <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(search_step(in_word));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_percent(1'b0)) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs so that the result slots fill and the input stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left  <= 0;
      stalls_done <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_done < 2 && n_accepted >= stall_at[stalls_done]) begin
      stall_left  <= STALL_LEN;
      stalls_done <= stalls_done + 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          note_error($sformatf("result word with nothing pending: status %0d offset %0d",
                               out_word.status, out_word.match_offset));
        end else begin
          head_result = expected_results.pop_front();
          if (out_word.status !== head_result.status)
            note_error($sformatf("result %0d: status %0d, expected %0d",
                                 n_results, out_word.status, head_result.status));
          if (out_word.match_offset !== head_result.match_offset)
            note_error($sformatf("result %0d: match_offset %0d, expected %0d",
                                 n_results, out_word.match_offset,
                                 head_result.match_offset));
          if (head_result.status == ST_MATCH) n_matches++;
          if (head_result.status == ST_NOT_FOUND) n_not_found++;
        end
      end
      out_ready <= (stall_left == 0) && ($urandom_range(99) >= idle_percent(1'b1));
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_cnt, expected_results.size());
      $display("** masked_byte_pattern_search: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    int unsigned plen;

    // Empty pattern: never matches, the region end reports not found.
    push_word(CMD_SCAN, 8'h00, 1'b0, 1'b0);
    push_word(CMD_SCAN, 8'hFF, 1'b1, 1'b1);
    push_word(CMD_UNUSED, 8'hFF, 1'b1, 1'b1);
    push_word(CMD_CLEAR, 8'h00, 1'b0, 1'b0);
    // Extreme bytes plus a wildcard; the match completes on the last byte.
    push_word(CMD_LOAD, 8'h00, 1'b1, 1'b0);
    push_word(CMD_LOAD, 8'hFF, 1'b1, 1'b1);
    push_word(CMD_LOAD, 8'h5A, 1'b0, 1'b0);
    push_word(CMD_SCAN, 8'h00, 1'b0, 1'b0);
    push_word(CMD_SCAN, 8'hFF, 1'b1, 1'b0);
    push_word(CMD_SCAN, 8'h12, 1'b0, 1'b1);
    // After the first match every scan word is ignored.
    push_word(CMD_SCAN, 8'h00, 1'b0, 1'b0);
    push_word(CMD_SCAN, 8'hFF, 1'b0, 1'b1);
    push_word(CMD_CLEAR, 8'hFF, 1'b1, 1'b1);
    push_word(CMD_LOAD, 8'hAB, 1'b1, 1'b0);
    push_word(CMD_SCAN, 8'h00, 1'b0, 1'b0);
    push_word(CMD_SCAN, 8'hAB, 1'b0, 1'b0);
    // A load after a match appends and restarts the scan.
    push_word(CMD_LOAD, 8'hCD, 1'b1, 1'b0);
    push_word(CMD_SCAN, 8'hAB, 1'b0, 1'b0);
    push_word(CMD_SCAN, 8'hCD, 1'b0, 1'b0);
    // A region without a match, then a fresh region starting at offset zero.
    push_word(CMD_CLEAR, 8'h00, 1'b0, 1'b0);
    push_word(CMD_LOAD, 8'h11, 1'b1, 1'b0);
    push_word(CMD_SCAN, 8'h22, 1'b0, 1'b1);
    push_word(CMD_SCAN, 8'h33, 1'b0, 1'b0);
    push_word(CMD_SCAN, 8'h11, 1'b0, 1'b0);

    // One full-length pattern, with a load past the end that must be dropped.
    queue_search(MAX_PATTERN + 1, 1, 1'b1);
    while (pending_words.size() < 1035) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        repeat ($urandom_range(4, 1)) begin
          push_word(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end
      end else begin
        if (sel < 13) plen = 0;
        else if (sel < 22) plen = $urandom_range(40, 9);
        else plen = $urandom_range(8, 1);
        queue_search(plen, $urandom_range(3, 1), $urandom_range(99) < 75);
      end
    end
    total_words = pending_words.size();
    stall_at[0] = total_words / 6;
    stall_at[1] = 2 * (total_words / 3) + 40;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Covered %0d words: %0d results checked, %0d first matches, %0d regions not found",
             n_accepted, n_results, n_matches, n_not_found);
    $display("Pattern lengths from empty to full, wildcards, loads mid-scan, %0d errors",
             err_cnt);
    if (err_cnt == 0) begin
      $display("** masked_byte_pattern_search: PASSED **");
    end else begin
      $display("** masked_byte_pattern_search: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mbps_pkg.sv
design/mbps_cell.sv
design/mbps_skid.sv
design/masked_byte_pattern_search.sv
tb/tb_top.sv
